### rtl/byte_stream_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// Byte stream tokenizer assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_TOKENIZER_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property while out of reset
`define BST_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bst check failed");

// Check a property at every edge, reset included
`define BST_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("bst check failed");

`else

`define BST_ASSERT(label, clk, rstn, prop)
`define BST_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer package
// Request types, token kinds, error codes and character classes.
// ----------------------------------------------------------------------------
package bst_pkg;

    // Source position and token geometry
    localparam int unsigned POS_W   = 21;
    localparam int unsigned START_W = 20;
    localparam logic [POS_W-1:0] MAX_SOURCE = 21'h100000;

    // Result queue geometry
    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // Token kinds
    localparam logic [4:0] KIND_IDENT    = 5'd0;
    localparam logic [4:0] KIND_INT      = 5'd1;
    localparam logic [4:0] KIND_LPAREN   = 5'd2;
    localparam logic [4:0] KIND_RPAREN   = 5'd3;
    localparam logic [4:0] KIND_LBRACE   = 5'd4;
    localparam logic [4:0] KIND_RBRACE   = 5'd5;
    localparam logic [4:0] KIND_LBRACKET = 5'd6;
    localparam logic [4:0] KIND_RBRACKET = 5'd7;
    localparam logic [4:0] KIND_EQUAL    = 5'd8;
    localparam logic [4:0] KIND_PLUS     = 5'd9;
    localparam logic [4:0] KIND_MINUS    = 5'd10;
    localparam logic [4:0] KIND_GREATER  = 5'd11;
    localparam logic [4:0] KIND_LESS     = 5'd12;
    localparam logic [4:0] KIND_COMMA    = 5'd13;
    localparam logic [4:0] KIND_COLON    = 5'd14;
    localparam logic [4:0] KIND_DOT      = 5'd15;
    localparam logic [4:0] KIND_QUESTION = 5'd16;
    localparam logic [4:0] KIND_SEMI     = 5'd17;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BYTE     = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // Characters
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    // Open run
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_INT   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [19:0] token_start;
        logic [20:0] token_length;
        logic [1:0]  error_code;
        logic        run_end;
    } out_t;

    // Results from one source byte, in order
    typedef struct packed {
        logic [1:0] cnt;
        out_t       res0;
        out_t       res1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))
            || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Kind of a single-character token, KIND_IDENT when the byte is none
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            8'h28:   k = KIND_LPAREN;   // (
            8'h29:   k = KIND_RPAREN;   // )
            8'h7B:   k = KIND_LBRACE;   // {
            8'h7D:   k = KIND_RBRACE;   // }
            8'h5B:   k = KIND_LBRACKET; // [
            8'h5D:   k = KIND_RBRACKET; // ]
            8'h3D:   k = KIND_EQUAL;    // =
            8'h2B:   k = KIND_PLUS;     // +
            8'h2D:   k = KIND_MINUS;    // -
            8'h3E:   k = KIND_GREATER;  // >
            8'h3C:   k = KIND_LESS;     // <
            8'h2C:   k = KIND_COMMA;    // ,
            8'h3A:   k = KIND_COLON;    // :
            8'h2E:   k = KIND_DOT;      // .
            8'h3F:   k = KIND_QUESTION; // ?
            8'h3B:   k = KIND_SEMI;     // ;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

endpackage

### rtl/byte_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer
// Source bytes in, identifier / integer / punctuation tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one source byte per request, with
//   final_byte set on the last byte of a source. m_valid/m_ready/m_data
//   carry tokens as kind, start offset and length, or error results.
//   A byte is registered in the input register, decided combinationally and
//   its zero, one or two results are written into a four-entry result queue
//   once the queue has room; m_valid is high while the queue holds a result.
//   One byte per cycle is taken while the queue has space for two results;
//   a byte that causes two results needs two pops by the receiver, so a
//   steady run of such bytes is paced by the receiver, not by the input.
//   A stalled receiver lets the queue fill, and s_ready is then held low.
//   Reset (aresetn low, synchronous) clears the open run, the position
//   and the queue. The position restarts at zero after each final byte.
// ----------------------------------------------------------------------------
`include "byte_stream_tokenizer_defines.svh"

module byte_stream_tokenizer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bst_pkg::in_t    s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output bst_pkg::out_t   m_data
);

    logic                   in_valid_reg, in_valid_next;
    bst_pkg::in_t           in_data_reg;
    logic                   room;
    logic                   fire;
    bst_pkg::push_t         push;

    // Hand the held byte to the lexer when the queue has space
    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the request payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    bst_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .push    (push)
    );

    bst_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `BST_ASSERT(a_hold_byte, aclk, aresetn,
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_data_reg)))
    `BST_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!in_valid_reg && !m_valid))

endmodule

### rtl/bst_lexer.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer lexer
// Run state and the per-byte decision; emits up to two results per byte.
// ----------------------------------------------------------------------------
`include "byte_stream_tokenizer_defines.svh"

module bst_lexer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  bst_pkg::in_t       item,
    output bst_pkg::push_t     push
);

    bst_pkg::mode_t                     mode_reg, mode_next;
    logic [bst_pkg::START_W-1:0]        begin_reg, begin_next;
    logic [bst_pkg::POS_W-1:0]          pos_reg, pos_next;

    logic                               ovf, dig, ids, spc;
    logic [4:0]                         pk;
    logic                               hit_a, hit_b, hit_f;
    bst_pkg::out_t                      res_a, res_b, res_f;
    bst_pkg::mode_t                     mode_mid, mode_new;
    logic [bst_pkg::START_W-1:0]        begin_new;
    logic [bst_pkg::POS_W-1:0]          pos_inc;
    logic [1:0]                         n;

    // Classify the byte and decide which results it causes
    always_comb begin
        ovf     = pos_reg >= bst_pkg::MAX_SOURCE;
        dig     = bst_pkg::is_digit(item.char_byte);
        ids     = bst_pkg::is_ident_start(item.char_byte);
        spc     = bst_pkg::is_space(item.char_byte);
        pk      = bst_pkg::punct_kind(item.char_byte);
        pos_inc = pos_reg + 21'd1;

        // Close the open run before this byte
        if (ovf) begin
            hit_a = mode_reg != bst_pkg::MODE_NONE;
        end else begin
            hit_a = ((mode_reg == bst_pkg::MODE_IDENT) && !(ids || dig))
                 || ((mode_reg == bst_pkg::MODE_INT) && !dig);
        end
        res_a.token_kind   = (mode_reg == bst_pkg::MODE_INT) ? bst_pkg::KIND_INT
                                                             : bst_pkg::KIND_IDENT;
        res_a.token_start  = begin_reg;
        res_a.token_length = pos_reg - {1'b0, begin_reg};
        res_a.error_code   = bst_pkg::ERR_NONE;
        res_a.run_end      = 1'b0;
        mode_mid = hit_a ? bst_pkg::MODE_NONE : mode_reg;

        // Handle the byte itself
        hit_b              = 1'b0;
        res_b.token_kind   = bst_pkg::KIND_IDENT;
        res_b.token_start  = pos_reg[bst_pkg::START_W-1:0];
        res_b.token_length = 21'd0;
        res_b.error_code   = bst_pkg::ERR_NONE;
        res_b.run_end      = 1'b0;
        mode_new  = mode_mid;
        begin_new = begin_reg;
        if (ovf) begin
            hit_b             = 1'b1;
            res_b.token_start = bst_pkg::MAX_SOURCE[bst_pkg::START_W-1:0];
            res_b.error_code  = bst_pkg::ERR_OVERFLOW;
        end else if (mode_mid == bst_pkg::MODE_NONE) begin
            if (pk != bst_pkg::KIND_IDENT) begin
                hit_b              = 1'b1;
                res_b.token_kind   = pk;
                res_b.token_length = 21'd1;
            end else if (dig) begin
                mode_new  = bst_pkg::MODE_INT;
                begin_new = pos_reg[bst_pkg::START_W-1:0];
            end else if (ids) begin
                mode_new  = bst_pkg::MODE_IDENT;
                begin_new = pos_reg[bst_pkg::START_W-1:0];
            end else if (!spc) begin
                hit_b            = 1'b1;
                res_b.error_code = bst_pkg::ERR_BYTE;
            end
        end

        // Flush the run on the final byte
        hit_f = !ovf && item.final_byte && (mode_new != bst_pkg::MODE_NONE);
        res_f.token_kind   = (mode_new == bst_pkg::MODE_INT) ? bst_pkg::KIND_INT
                                                             : bst_pkg::KIND_IDENT;
        res_f.token_start  = begin_new;
        res_f.token_length = pos_inc - {1'b0, begin_new};
        res_f.error_code   = bst_pkg::ERR_NONE;
        res_f.run_end      = 1'b0;
    end

    // Pack the results into two slots
    always_comb begin
        n = 2'({1'b0, hit_a} + {1'b0, hit_b} + {1'b0, hit_f});
        push.cnt  = fire ? n : 2'd0;
        push.res0 = hit_a ? res_a : (hit_b ? res_b : res_f);
        push.res1 = (hit_a && hit_b) ? res_b : res_f;
        push.res0.run_end = (n == 2'd1);
        push.res1.run_end = 1'b1;
    end

    // Next run state
    always_comb begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        pos_next   = pos_reg;
        if (fire) begin
            mode_next  = hit_f ? bst_pkg::MODE_NONE : mode_new;
            begin_next = begin_new;
            if (item.final_byte) begin
                pos_next = '0;
            end else if (!ovf) begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= bst_pkg::MODE_NONE;
            begin_reg <= '0;
            pos_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
        end
    end

    `BST_ASSERT(a_pos_bound, aclk, aresetn, pos_reg <= bst_pkg::MAX_SOURCE)
    `BST_ASSERT(a_final_rewinds, aclk, aresetn,
        (fire && item.final_byte) |=> (pos_reg == '0 && mode_reg == bst_pkg::MODE_NONE))

endmodule

### rtl/bst_out_fifo.sv
// ----------------------------------------------------------------------------
// Byte stream tokenizer result queue
// Small queue that takes up to two results a cycle while it has room and drains one while m_ready is high.
// ----------------------------------------------------------------------------
`include "byte_stream_tokenizer_defines.svh"

module bst_out_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bst_pkg::push_t            push,
    output logic                      room,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bst_pkg::out_t             m_data
);

    bst_pkg::out_t                    mem_reg [bst_pkg::DEPTH];
    logic [bst_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [bst_pkg::PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [bst_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                             pop;
    logic [bst_pkg::PTR_W-1:0]        wr_ptr_b;

    // Leave space for two results
    assign room    = count_reg <= bst_pkg::CNT_W'(bst_pkg::DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign wr_ptr_b = wr_ptr_reg + bst_pkg::PTR_W'(1);

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + bst_pkg::PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + bst_pkg::PTR_W'(pop);
        count_next  = count_reg + bst_pkg::CNT_W'(push.cnt) - bst_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the new results
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_b] <= push.res1;
        end
    end

    `BST_ASSERT(a_push_fits, aclk, aresetn,
        (push.cnt != 2'd0) |-> room)
    `BST_ASSERT(a_ptr_track, aclk, aresetn,
        bst_pkg::PTR_W'(wr_ptr_reg - rd_ptr_reg) == bst_pkg::PTR_W'(count_reg))

endmodule
